// File: src/qat_pkg.sv
// Package: shared types, character codes and option bits of the argument tokenizer.
`timescale 1ns / 1ps

package qat_pkg;

    // Character codes
    localparam logic [7:0] CH_TAB    = 8'd9;
    localparam logic [7:0] CH_LF     = 8'd10;
    localparam logic [7:0] CH_CR     = 8'd13;
    localparam logic [7:0] CH_SPACE  = 8'd32;
    localparam logic [7:0] CH_DQUOTE = 8'd34;
    localparam logic [7:0] CH_HASH   = 8'd35;
    localparam logic [7:0] CH_SQUOTE = 8'd39;
    localparam logic [7:0] CH_LPAREN = 8'd40;
    localparam logic [7:0] CH_RPAREN = 8'd41;
    localparam logic [7:0] CH_COMMA  = 8'd44;
    localparam logic [7:0] CH_LBRACE = 8'd123;
    localparam logic [7:0] CH_RBRACE = 8'd125;

    // Option register bit positions
    localparam int OPT_QUOTES = 0;
    localparam int OPT_STRIP  = 1;
    localparam int OPT_CURLY  = 2;
    localparam int OPT_COMMAS = 3;
    localparam int OPT_W      = 4;

    // Default depth of the queue between classifier and state unit
    localparam int QUEUE_DEPTH_DEF = 4;

    // Character class after the options are applied
    typedef enum logic [2:0] {
        CLS_NORMAL = 3'd0,
        CLS_DROP   = 3'd1,
        CLS_DELIM  = 3'd2,
        CLS_EOL    = 3'd3,
        CLS_DQUOTE = 3'd4,
        CLS_SQUOTE = 3'd5,
        CLS_LBRACE = 3'd6,
        CLS_RBRACE = 3'd7
    } t_cls;

    // Quoting state, one-hot
    typedef enum logic [3:0] {
        QM_NONE   = 4'b0001,
        QM_DOUBLE = 4'b0010,
        QM_SINGLE = 4'b0100,
        QM_BRACE  = 4'b1000
    } t_qmode;

    // Classified beat travelling through the queue
    typedef struct packed {
        t_cls       cls;
        logic [7:0] ch;
        logic       last;
    } t_item;

endpackage

// File: src/qat_front.sv
// Front classifier: maps each character to its class under the current options.
`timescale 1ns / 1ps

module qat_front (
    input  logic [7:0]               i_char_code,
    input  logic                     i_last_in_line,
    input  logic [qat_pkg::OPT_W-1:0] i_options,
    output qat_pkg::t_item           o_item
);

    qat_pkg::t_cls w_cls;

    // Decode the character; options fold quote, brace, comma and paren handling in
    always_comb begin
        case (i_char_code)
            qat_pkg::CH_LF, qat_pkg::CH_CR, qat_pkg::CH_HASH: begin
                w_cls = qat_pkg::CLS_EOL;
            end
            qat_pkg::CH_COMMA: begin
                w_cls = i_options[qat_pkg::OPT_COMMAS] ? qat_pkg::CLS_NORMAL
                                                       : qat_pkg::CLS_DELIM;
            end
            qat_pkg::CH_TAB, qat_pkg::CH_SPACE: begin
                w_cls = qat_pkg::CLS_DELIM;
            end
            qat_pkg::CH_DQUOTE: begin
                w_cls = i_options[qat_pkg::OPT_QUOTES] ? qat_pkg::CLS_DQUOTE
                                                       : qat_pkg::CLS_DROP;
            end
            qat_pkg::CH_SQUOTE: begin
                w_cls = i_options[qat_pkg::OPT_QUOTES] ? qat_pkg::CLS_SQUOTE
                                                       : qat_pkg::CLS_DROP;
            end
            qat_pkg::CH_LBRACE: begin
                w_cls = i_options[qat_pkg::OPT_CURLY] ? qat_pkg::CLS_LBRACE
                                                      : qat_pkg::CLS_NORMAL;
            end
            qat_pkg::CH_RBRACE: begin
                w_cls = i_options[qat_pkg::OPT_CURLY] ? qat_pkg::CLS_RBRACE
                                                      : qat_pkg::CLS_NORMAL;
            end
            qat_pkg::CH_LPAREN, qat_pkg::CH_RPAREN: begin
                w_cls = i_options[qat_pkg::OPT_STRIP] ? qat_pkg::CLS_DROP
                                                      : qat_pkg::CLS_NORMAL;
            end
            default: begin
                w_cls = qat_pkg::CLS_NORMAL;
            end
        endcase
    end

    assign o_item.cls  = w_cls;
    assign o_item.ch   = i_char_code;
    assign o_item.last = i_last_in_line;

endmodule

// File: src/qat_queue.sv
// Short queue of classified beats between the classifier and the state unit.
`timescale 1ns / 1ps

module qat_queue #(
    parameter int DEPTH = qat_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  qat_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output qat_pkg::t_item o_item
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    qat_pkg::t_item r_mem [DEPTH];
    logic [PW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]  r_count,  n_count;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rd_ptr];

    // Advance pointers with wrap at the depth
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the beat
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// File: src/qat_back.sv
// Back state unit: quoting state, argument tracking and the registered result beat.
`timescale 1ns / 1ps

module qat_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  qat_pkg::t_item i_item,
    output logic           o_pop,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic           o_append_valid,
    output logic [7:0]     o_append_char,
    output logic           o_token_end,
    output logic           o_token_kept,
    output logic           o_line_end
);

    qat_pkg::t_qmode r_qmode, n_qmode;
    logic            r_nonempty, n_nonempty;
    logic            r_had_quotes, n_had_quotes;
    logic            r_skip, n_skip;
    logic            r_out_valid;
    logic            r_app, r_end, r_kept, r_eol;
    logic [7:0]      r_char;

    logic            w_app, w_done, w_eol, w_end, w_kept, w_line;
    qat_pkg::t_qmode w_mine;
    logic            w_quoting;

    // Take the next beat when the result register is free or being drained
    assign o_pop = !i_empty && (!r_out_valid || i_out_ready);

    assign w_quoting = (r_qmode != qat_pkg::QM_NONE);
    assign w_mine    = (i_item.cls == qat_pkg::CLS_DQUOTE) ? qat_pkg::QM_DOUBLE
                                                           : qat_pkg::QM_SINGLE;

    // Per-class state update
    always_comb begin
        n_qmode      = r_qmode;
        n_nonempty   = r_nonempty;
        n_had_quotes = r_had_quotes;
        n_skip       = r_skip;
        w_app        = 1'b0;
        w_done       = 1'b0;
        w_eol        = 1'b0;
        w_end        = 1'b0;
        w_kept       = 1'b0;
        w_line       = 1'b0;
        if (r_skip) begin
            // Drop the rest of the line; clear on its last character
            if (i_item.last) begin
                n_skip       = 1'b0;
                n_qmode      = qat_pkg::QM_NONE;
                n_nonempty   = 1'b0;
                n_had_quotes = 1'b0;
            end
        end else begin
            case (i_item.cls)
                qat_pkg::CLS_EOL: begin
                    w_done = 1'b1;
                    w_eol  = 1'b1;
                end
                qat_pkg::CLS_DELIM: begin
                    if (w_quoting) begin
                        w_app = 1'b1;
                    end else if (r_nonempty) begin
                        w_done = 1'b1;
                    end
                end
                qat_pkg::CLS_DQUOTE, qat_pkg::CLS_SQUOTE: begin
                    if (!w_quoting) begin
                        n_qmode = w_mine;
                    end else if (r_qmode == w_mine) begin
                        n_qmode      = qat_pkg::QM_NONE;
                        n_had_quotes = 1'b1;
                        w_done       = 1'b1;
                    end else begin
                        w_app = 1'b1;
                    end
                end
                qat_pkg::CLS_LBRACE: begin
                    w_app   = w_quoting;
                    n_qmode = qat_pkg::QM_BRACE;
                end
                qat_pkg::CLS_RBRACE: begin
                    if (r_qmode == qat_pkg::QM_BRACE) begin
                        n_qmode = qat_pkg::QM_NONE;
                    end else begin
                        w_app = w_quoting;
                    end
                end
                qat_pkg::CLS_DROP: begin
                    w_app = 1'b0;
                end
                qat_pkg::CLS_NORMAL: begin
                    w_app = 1'b1;
                end
                default: begin
                    w_app = 1'b0;
                end
            endcase
            if (w_app) begin
                n_nonempty = 1'b1;
            end
            // Close the argument on a terminator or the final character
            if (w_done || i_item.last) begin
                w_end        = 1'b1;
                w_kept       = n_nonempty || n_had_quotes;
                n_qmode      = qat_pkg::QM_NONE;
                n_nonempty   = 1'b0;
                n_had_quotes = 1'b0;
            end
            w_line = w_eol || i_item.last;
            if (w_eol && !i_item.last) begin
                n_skip = 1'b1;
            end
        end
    end

    // State and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qmode      <= qat_pkg::QM_NONE;
            r_nonempty   <= 1'b0;
            r_had_quotes <= 1'b0;
            r_skip       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_pop) begin
                r_qmode      <= n_qmode;
                r_nonempty   <= n_nonempty;
                r_had_quotes <= n_had_quotes;
                r_skip       <= n_skip;
            end
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_app  <= w_app;
            r_char <= w_app ? i_item.ch : 8'd0;
            r_end  <= w_end;
            r_kept <= w_kept;
            r_eol  <= w_line;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_append_valid = r_app;
    assign o_append_char  = r_char;
    assign o_token_end    = r_end;
    assign o_token_kept   = r_kept;
    assign o_line_end     = r_eol;

endmodule

// File: src/quoted_argument_tokenizer_unit.sv
// Top level of the quoted argument tokenizer: classifier, queue and state unit.
`timescale 1ns / 1ps

// Takes one character of a text line per beat and returns one result beat per
// character: whether it joins the current argument, whether the argument ends
// and is kept, and whether the line is over. Throughput is one character per
// clock while the result side keeps up. A character's result goes through the
// queue and then the result register before it is offered. The queue of
// QUEUE_DEPTH beats lets input keep flowing while the result side stalls, and
// input ready drops only when the queue is full. The option register is
// written through the config channel, which is always ready; write it only
// while no characters are in flight.

module quoted_argument_tokenizer_unit #(
    parameter int QUEUE_DEPTH = qat_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [qat_pkg::OPT_W-1:0] i_cfg_option_bits,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [7:0]                i_char_code,
    input  logic                      i_last_in_line,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic                      o_append_valid,
    output logic [7:0]                o_append_char,
    output logic                      o_token_end,
    output logic                      o_token_kept,
    output logic                      o_line_end
);

    logic [qat_pkg::OPT_W-1:0] r_options;
    qat_pkg::t_item            w_front_item;
    qat_pkg::t_item            w_queue_item;
    logic                      w_full, w_empty, w_pop, w_push;

    // Option register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_options <= '0;
        end else if (i_cfg_valid) begin
            r_options <= i_cfg_option_bits;
        end
    end

    assign o_in_ready = !w_full;
    assign w_push     = i_in_valid && !w_full;

    qat_front u_front (
        .i_char_code    (i_char_code),
        .i_last_in_line (i_last_in_line),
        .i_options      (r_options),
        .o_item         (w_front_item)
    );

    qat_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_item  (w_queue_item)
    );

    qat_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (w_empty),
        .i_item         (w_queue_item),
        .o_pop          (w_pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_append_valid (o_append_valid),
        .o_append_char  (o_append_char),
        .o_token_end    (o_token_end),
        .o_token_kept   (o_token_kept),
        .o_line_end     (o_line_end)
    );

    // A kept argument is always an ended one
    a_kept_needs_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!o_token_kept || o_token_end))
        else $error("token_kept without token_end");

    // A character that is not appended is reported as zero
    a_char_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_append_valid) |-> (o_append_char == 8'd0))
        else $error("append_char nonzero without append_valid");

    // A full queue never takes another beat
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_full |-> !w_push)
        else $error("push into full queue");

endmodule
